/* design/hkvt_pkg.sv */
// Shared constants and types for the hashed key-value table.
// Used by hkvt_mix_unit and hashed_key_value_table; depends on nothing.
`default_nettype none
package hkvt_pkg;

    // table geometry
    localparam int BUCKET_BITS = 3;
    localparam int WAYS        = 4;
    localparam int VALUE_BYTES = 8;

    localparam int BUCKETS = 1 << BUCKET_BITS;
    localparam int ENTRIES = BUCKETS * WAYS;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int CNT_W   = $clog2(WAYS + 1);
    localparam int VALUE_W = 8 * VALUE_BYTES;

    // field widths
    localparam int KEY_W  = 32;
    localparam int DATA_W = 64;

    // murmur3 finalizer multipliers
    localparam logic [31:0] MIX_C1 = 32'h85eb_ca6b;
    localparam logic [31:0] MIX_C2 = 32'hc2b2_ae35;

    // operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DUP  = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    // sequencer controls for the hash unit
    typedef struct packed {
        logic load;   // take a new key
        logic mul1;   // first multiply round
        logic mul2;   // second multiply round
    } mix_ctl_t;

endpackage
`default_nettype wire

/* design/hkvt_mix_unit.sv */
// murmur3 32-bit finalizer, one shared 32x32 multiplier used over two rounds.
// Depends on hkvt_pkg (constants, mix_ctl_t).
`default_nettype none
module hkvt_mix_unit (
    input  wire logic                  aclk,
    input  wire logic [31:0]           key,
    input  wire hkvt_pkg::mix_ctl_t    ctl,
    output logic [31:0]                hash
);

    logic [31:0] h_reg;
    logic [31:0] mult_sel;
    logic [31:0] prod;

    assign mult_sel = ctl.mul1 ? hkvt_pkg::MIX_C1 : hkvt_pkg::MIX_C2;
    // only the low word of the product is kept
    assign prod     = h_reg * mult_sel;

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            h_reg <= key ^ (key >> 16);
        end else if (ctl.mul1) begin
            h_reg <= prod ^ (prod >> 13);
        end else if (ctl.mul2) begin
            h_reg <= prod ^ (prod >> 16);
        end
    end

    assign hash = h_reg;

endmodule
`default_nettype wire

/* design/hashed_key_value_table.sv */
// Hashed key-value table, bucket from murmur3 fmix32 of the key; uses hkvt_pkg, hkvt_mix_unit.
// A result is loaded into the output register for m_valid in S_EXEC, after S_MUL1, S_MUL2, S_PROBE.
// One item at a time: s_ready is high only in S_IDLE, so the next item waits out two rounds of the
// shared multiplier, the way probe through the single read port of the entry memory, and S_EXEC.
// Reset: synchronous active-low aresetn clears all entry valid bits and the sequencer;
// key and value storage is not cleared. s_ready stays low while aresetn is low.
`default_nettype none
module hashed_key_value_table (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // request items
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_op,
    input  wire logic [31:0] s_key,
    input  wire logic [63:0] s_value,
    // result items
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic [31:0]      m_key_out,
    output logic [63:0]      m_value_out
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_PROBE,
        S_EXEC
    } state_t;

    state_t state_reg;

    // request held for the whole item
    logic [1:0]                          op_reg;
    logic [hkvt_pkg::KEY_W-1:0]          key_reg;
    logic [hkvt_pkg::VALUE_W-1:0]        val_reg;

    // probe sequencing
    logic [hkvt_pkg::CNT_W-1:0]          cnt_reg;
    logic                                cmp_pend_reg;
    logic [hkvt_pkg::WAY_W-1:0]          cmp_way_reg;
    logic                                hit_found_reg;
    logic [hkvt_pkg::WAY_W-1:0]          hit_way_reg;
    logic [hkvt_pkg::VALUE_W-1:0]        hit_val_reg;
    logic                                free_found_reg;
    logic [hkvt_pkg::WAY_W-1:0]          free_way_reg;

    // entry storage: valid bits in flops, key/value in memory
    logic [hkvt_pkg::ENTRIES-1:0]        valid_reg;
    logic [hkvt_pkg::KEY_W-1:0]          key_mem   [hkvt_pkg::ENTRIES];
    logic [hkvt_pkg::VALUE_W-1:0]        val_mem   [hkvt_pkg::ENTRIES];
    logic [hkvt_pkg::KEY_W-1:0]          rd_key_reg;
    logic [hkvt_pkg::VALUE_W-1:0]        rd_val_reg;

    // output register
    logic                                m_valid_reg;
    logic [1:0]                          m_status_reg;
    logic [hkvt_pkg::KEY_W-1:0]          m_key_reg;
    logic [hkvt_pkg::DATA_W-1:0]         m_value_reg;

    // hash unit
    hkvt_pkg::mix_ctl_t                  mix_ctl;
    logic [31:0]                         hash;
    logic [hkvt_pkg::BUCKET_BITS-1:0]    bucket;

    logic                                s_fire;
    logic                                issue;
    logic [hkvt_pkg::WAY_W-1:0]          issue_way;
    logic [hkvt_pkg::IDX_W-1:0]          rd_idx;
    logic [hkvt_pkg::IDX_W-1:0]          cmp_idx;
    logic [hkvt_pkg::IDX_W-1:0]          hit_idx;
    logic [hkvt_pkg::IDX_W-1:0]          free_idx;
    logic                                out_free;
    logic                                exec_go;

    // result of the execute step
    logic [1:0]                          res_status;
    logic [hkvt_pkg::DATA_W-1:0]         res_value;
    logic                                mem_we;
    logic                                clr_hit;

    function automatic logic [hkvt_pkg::IDX_W-1:0] entry_idx(
        input logic [hkvt_pkg::BUCKET_BITS-1:0] b,
        input logic [hkvt_pkg::WAY_W-1:0]       w
    );
        logic [hkvt_pkg::IDX_W-1:0] base;
        base = hkvt_pkg::IDX_W'(b) * hkvt_pkg::IDX_W'(hkvt_pkg::WAYS);
        return base + hkvt_pkg::IDX_W'(w);
    endfunction

    // no item is taken while reset is held
    assign s_ready = aresetn && (state_reg == S_IDLE);
    assign s_fire  = s_valid && s_ready;

    assign mix_ctl.load = s_fire;
    assign mix_ctl.mul1 = (state_reg == S_MUL1);
    assign mix_ctl.mul2 = (state_reg == S_MUL2);

    hkvt_mix_unit u_mix (
        .aclk (aclk),
        .key  (s_key),
        .ctl  (mix_ctl),
        .hash (hash)
    );

    // bucket = top bits of the finished hash, stable through probe and execute
    assign bucket = hash[31 -: hkvt_pkg::BUCKET_BITS];

    assign issue     = (state_reg == S_PROBE) &&
                       (cnt_reg < hkvt_pkg::CNT_W'(hkvt_pkg::WAYS));
    assign issue_way = cnt_reg[hkvt_pkg::WAY_W-1:0];
    assign rd_idx    = entry_idx(bucket, issue_way);
    assign cmp_idx   = entry_idx(bucket, cmp_way_reg);
    assign hit_idx   = entry_idx(bucket, hit_way_reg);
    assign free_idx  = entry_idx(bucket, free_way_reg);

    // output stage free to take a new result
    assign out_free = !m_valid_reg || m_ready;
    assign exec_go  = (state_reg == S_EXEC) && out_free;

    always_comb begin
        res_status = hkvt_pkg::ST_MISS;
        res_value  = '0;
        mem_we     = 1'b0;
        clr_hit    = 1'b0;
        case (op_reg)
            hkvt_pkg::OP_INSERT: begin
                if (hit_found_reg) begin
                    res_status = hkvt_pkg::ST_DUP;
                end else if (!free_found_reg) begin
                    res_status = hkvt_pkg::ST_FULL;
                end else begin
                    res_status = hkvt_pkg::ST_OK;
                    res_value  = hkvt_pkg::DATA_W'(val_reg);
                    mem_we     = exec_go;
                end
            end
            hkvt_pkg::OP_REMOVE: begin
                // a miss on remove still reports ok
                res_status = hkvt_pkg::ST_OK;
                res_value  = hkvt_pkg::DATA_W'(val_reg);
                clr_hit    = exec_go && hit_found_reg;
            end
            hkvt_pkg::OP_LOOKUP: begin
                if (hit_found_reg) begin
                    res_status = hkvt_pkg::ST_OK;
                    res_value  = hkvt_pkg::DATA_W'(hit_val_reg);
                end
            end
            default: begin
                res_status = hkvt_pkg::ST_MISS;
            end
        endcase
    end

    // entry memory: one write, one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            key_mem[free_idx] <= key_reg;
            val_mem[free_idx] <= val_reg;
        end
        if (issue) begin
            rd_key_reg <= key_mem[rd_idx];
            rd_val_reg <= val_mem[rd_idx];
        end
    end

    // sequencer, probe tracking, valid bits and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            valid_reg      <= '0;
            cmp_pend_reg   <= 1'b0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            cnt_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            // a result taken in the cycle a new one is loaded is replaced below
            if (m_valid_reg && m_ready && !exec_go) begin
                m_valid_reg <= 1'b0;
            end

            cmp_pend_reg <= issue;
            if (issue) begin
                cmp_way_reg <= issue_way;
                cnt_reg     <= cnt_reg + 1'b1;
            end

            // compare the entry read last cycle; first matching way wins,
            // first free way is the insert slot
            if (cmp_pend_reg) begin
                if (valid_reg[cmp_idx]) begin
                    if (!hit_found_reg && (rd_key_reg == key_reg)) begin
                        hit_found_reg <= 1'b1;
                        hit_way_reg   <= cmp_way_reg;
                        hit_val_reg   <= rd_val_reg;
                    end
                end else if (!free_found_reg) begin
                    free_found_reg <= 1'b1;
                    free_way_reg   <= cmp_way_reg;
                end
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_fire) begin
                        op_reg         <= s_op;
                        key_reg        <= s_key;
                        val_reg        <= s_value[hkvt_pkg::VALUE_W-1:0];
                        hit_found_reg  <= 1'b0;
                        free_found_reg <= 1'b0;
                        cnt_reg        <= '0;
                        state_reg      <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    state_reg <= S_MUL2;
                end
                S_MUL2: begin
                    state_reg <= S_PROBE;
                end
                S_PROBE: begin
                    // last way is compared in the cycle nothing is issued
                    if (!issue) begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= res_status;
                        m_key_reg    <= key_reg;
                        m_value_reg  <= res_value;
                        if (mem_we) begin
                            valid_reg[free_idx] <= 1'b1;
                        end
                        if (clr_hit) begin
                            valid_reg[hit_idx] <= 1'b0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_key_out   = m_key_reg;
    assign m_value_out = m_value_reg;

    // only ok results carry a value
    a_value_only_on_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != hkvt_pkg::ST_OK)) |-> (m_value_out == '0))
        else $error("nonzero value on a failed result");

    // a way is never both a hit and the free slot
    a_hit_free_apart: assert property (@(posedge aclk) disable iff (!aresetn)
        (hit_found_reg && free_found_reg) |-> (hit_way_reg != free_way_reg))
        else $error("hit way and free way coincide");

    // a duplicate only comes from an insert
    a_dup_from_insert: assert property (@(posedge aclk) disable iff (!aresetn)
        (exec_go && (res_status == hkvt_pkg::ST_DUP)) |-> (op_reg == hkvt_pkg::OP_INSERT))
        else $error("duplicate status on a non-insert");

    // an insert write leaves the slot valid
    a_insert_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |=> valid_reg[$past(free_idx)])
        else $error("inserted entry not marked valid");

    // a new result only comes out of the execute step
    a_result_from_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> ($past(state_reg) == S_EXEC))
        else $error("result raised outside execute");

endmodule
`default_nettype wire

/* tb/tb_hashed_key_value_table.sv */
// Self-checking bench for hashed_key_value_table: insert, remove and lookup items
// are checked against an in-bench table model under random idling on both channels.
// Depends on hkvt_pkg and the hashed_key_value_table RTL.
module tb_hashed_key_value_table;

    localparam int KEY_W      = hkvt_pkg::KEY_W;
    localparam int DATA_W     = hkvt_pkg::DATA_W;
    localparam int WAYS       = hkvt_pkg::WAYS;
    localparam int BUCKETS    = hkvt_pkg::BUCKETS;
    localparam int ENTRIES    = hkvt_pkg::ENTRIES;
    localparam int POOL_N     = 6;                  // keys kept per bucket for collisions
    localparam int DRAIN_WAIT = 2 * (WAYS + 5) + 4; // settle time after the last result
    localparam int STALL_MAX  = 2000;               // cycles with no handshake at all
    localparam int N_RANDOM   = 1100;

    localparam logic [DATA_W-1:0] VALUE_MASK =
        {DATA_W{1'b1}} >> (DATA_W - hkvt_pkg::VALUE_W);
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]        op;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] value;
        logic              drain;    // hold this item until no result is outstanding
    } kv_request_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] value;
    } kv_result_t;

    logic              aclk;
    logic              aresetn     = 1'b0;
    logic              s_valid     = 1'b0;
    logic              s_ready;
    logic [1:0]        s_op        = hkvt_pkg::OP_LOOKUP;
    logic [KEY_W-1:0]  s_key       = '0;
    logic [DATA_W-1:0] s_value     = '0;
    logic              m_valid;
    logic              m_ready     = 1'b0;
    logic [1:0]        m_status;
    logic [KEY_W-1:0]  m_key_out;
    logic [DATA_W-1:0] m_value_out;

    hashed_key_value_table dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .s_key       (s_key),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_key_out   (m_key_out),
        .m_value_out (m_value_out)
    );

    // Table model: mirrors entry valid/key/value of every way in every bucket.
    logic              tbl_valid [ENTRIES];
    logic [KEY_W-1:0]  tbl_key   [ENTRIES];
    logic [DATA_W-1:0] tbl_value [ENTRIES];

    kv_request_t pending_requests[$];  // items waiting to be driven
    kv_result_t  expected_results[$];  // predicted results, oldest first
    int          in_flight   = 0;      // expected_results depth, registered
    int          n_taken     = 0;      // input items accepted so far
    int          quiet_count = 0;      // cycles since the last handshake
    int          errors      = 0;

    // Keys sorted by bucket, so random traffic keeps hitting full buckets.
    logic [KEY_W-1:0] key_pool [BUCKETS][POOL_N];

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // murmur3 32-bit finalizer
    function automatic logic [31:0] fmix32(input logic [31:0] k);
        logic [31:0] h;
        h = k;
        h ^= h >> 16;
        h = h * hkvt_pkg::MIX_C1;
        h ^= h >> 13;
        h = h * hkvt_pkg::MIX_C2;
        h ^= h >> 16;
        return h;
    endfunction

    function automatic int bucket_of(input logic [KEY_W-1:0] k);
        return int'(fmix32(k) >> (32 - hkvt_pkg::BUCKET_BITS));
    endfunction

    // Apply one request to the table model and return the result it gives.
    function automatic kv_result_t apply_request(input logic [1:0] op,
                                                 input logic [KEY_W-1:0] k,
                                                 input logic [DATA_W-1:0] v_in);
        kv_result_t  r;
        int          base;
        int          hit;
        int          free_way;
        logic [DATA_W-1:0] v;
        v        = v_in & VALUE_MASK;
        base     = bucket_of(k) * WAYS;
        hit      = -1;
        free_way = -1;
        for (int w = 0; w < WAYS; w++) begin
            if (tbl_valid[base + w]) begin
                if (hit < 0 && tbl_key[base + w] == k) hit = base + w;
            end else if (free_way < 0) begin
                free_way = base + w;
            end
        end
        r.key   = k;
        r.value = '0;
        case (op)
            hkvt_pkg::OP_INSERT: begin
                if (hit >= 0) begin
                    r.status = hkvt_pkg::ST_DUP;
                end else if (free_way < 0) begin
                    r.status = hkvt_pkg::ST_FULL;
                end else begin
                    // lowest free way takes the new entry
                    tbl_valid[free_way] = 1'b1;
                    tbl_key[free_way]   = k;
                    tbl_value[free_way] = v;
                    r.status = hkvt_pkg::ST_OK;
                    r.value  = v;
                end
            end
            hkvt_pkg::OP_REMOVE: begin
                // a remove that misses still reports ok and echoes the value
                if (hit >= 0) tbl_valid[hit] = 1'b0;
                r.status = hkvt_pkg::ST_OK;
                r.value  = v;
            end
            hkvt_pkg::OP_LOOKUP: begin
                if (hit >= 0) begin
                    r.status = hkvt_pkg::ST_OK;
                    r.value  = tbl_value[hit] & VALUE_MASK;
                end else begin
                    r.status = hkvt_pkg::ST_MISS;
                end
            end
            default: r.status = hkvt_pkg::ST_MISS;  // unused code leaves the table alone
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("mismatch on %s at item %0d: got %h, expected %h", what, n_taken, got, want);
        errors++;
    endtask

    task automatic add_request(input logic [1:0] op, input logic [KEY_W-1:0] k,
                               input logic [DATA_W-1:0] v, input logic drain);
        kv_request_t req;
        req.op    = op;
        req.key   = k;
        req.value = v;
        req.drain = drain;
        pending_requests.push_back(req);
    endtask

    // Idling: three phases by accepted item count.
    // Phase 0 sender 24% / receiver 82%, phase 1 swapped, phase 2 no idling.
    function automatic int send_idle_pct();
        if (n_taken < 380) return 24;
        if (n_taken < 760) return 82;
        return 0;
    endfunction

    function automatic int recv_stall_pct();
        if (n_taken < 380) return 82;
        if (n_taken < 760) return 24;
        return 0;
    endfunction

    // Driver: presents the next item once the bus is free; valid holds until accepted.
    always @(posedge aclk) begin
        logic bus_busy;
        logic send;
        bus_busy = s_valid && !s_ready;
        send     = 1'b0;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!bus_busy) begin
            if (pending_requests.size() != 0) begin
                send = ($urandom_range(99) >= send_idle_pct());
                // drain item: nothing on the bus and nothing outstanding first
                if (pending_requests[0].drain && (s_valid || in_flight != 0)) send = 1'b0;
            end
            if (send) begin
                s_valid <= 1'b1;
                s_op    <= pending_requests[0].op;
                s_key   <= pending_requests[0].key;
                s_value <= pending_requests[0].value;
                void'(pending_requests.pop_front());
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: predicts on input handshakes, checks result items, drives m_ready,
    // and runs the no-progress watchdog.
    always @(posedge aclk) begin
        kv_result_t want;
        logic       moved;
        moved = 1'b0;
        if (aresetn) begin
            // check first, so a result can never match its own item's handshake
            if (m_valid && m_ready) begin
                moved = 1'b1;
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing pending, key",
                                    DATA_W'(m_key_out), '0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_status !== want.status)
                        report_mismatch("status", DATA_W'(m_status), DATA_W'(want.status));
                    if (m_key_out !== want.key)
                        report_mismatch("key_out", DATA_W'(m_key_out), DATA_W'(want.key));
                    if (m_value_out !== want.value)
                        report_mismatch("value_out", m_value_out, want.value);
                end
            end
            if (s_valid && s_ready) begin
                moved = 1'b1;
                expected_results.push_back(apply_request(s_op, s_key, s_value));
                n_taken <= n_taken + 1;
            end
            in_flight   <= expected_results.size();
            m_ready     <= ($urandom_range(99) >= recv_stall_pct());
            quiet_count <= moved ? 0 : quiet_count + 1;
            if (quiet_count >= STALL_MAX) begin
                $display("timeout: no handshake for %0d cycles", STALL_MAX);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        int          cnt [BUCKETS];
        int          b;
        int          r;
        logic [KEY_W-1:0]  k;
        logic [DATA_W-1:0] v;
        logic [1:0]        op;
        logic              full_pool;

        for (int i = 0; i < ENTRIES; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_key[i]   = '0;
            tbl_value[i] = '0;
        end

        // gather POOL_N keys for each bucket
        for (int i = 0; i < BUCKETS; i++) cnt[i] = 0;
        full_pool = 1'b0;
        while (!full_pool) begin
            k = $urandom;
            b = bucket_of(k);
            if (cnt[b] < POOL_N) begin
                key_pool[b][cnt[b]] = k;
                cnt[b]++;
            end
            full_pool = 1'b1;
            for (int i = 0; i < BUCKETS; i++) if (cnt[i] < POOL_N) full_pool = 1'b0;
        end

        // directed: key and value extremes, each op, each special case
        add_request(hkvt_pkg::OP_INSERT, '0, '1, 1'b0);
        add_request(hkvt_pkg::OP_INSERT, '1, '0, 1'b0);
        add_request(hkvt_pkg::OP_LOOKUP, '0, '0, 1'b0);
        add_request(hkvt_pkg::OP_LOOKUP, '1, '1, 1'b0);
        add_request(hkvt_pkg::OP_INSERT, '0, 64'h5, 1'b0);                 // duplicate key
        add_request(hkvt_pkg::OP_LOOKUP, key_pool[1][POOL_N-1], '1, 1'b0);  // lookup miss
        add_request(hkvt_pkg::OP_REMOVE, key_pool[1][POOL_N-1], 64'h0123_4567_89ab_cdef,
                    1'b0);
        add_request(hkvt_pkg::OP_REMOVE, '0, 64'haaaa_aaaa_aaaa_aaaa, 1'b0);
        add_request(hkvt_pkg::OP_LOOKUP, '0, '0, 1'b0);
        add_request(OP_UNUSED, '1, 64'h5555_5555_5555_5555, 1'b0);
        add_request(hkvt_pkg::OP_LOOKUP, '1, '0, 1'b0);     // unused op left it alone
        // fill one bucket, then overflow it
        for (int i = 0; i < WAYS + 1; i++)
            add_request(hkvt_pkg::OP_INSERT, key_pool[0][i], {$urandom, $urandom}, 1'b0);
        add_request(hkvt_pkg::OP_LOOKUP, key_pool[0][WAYS], '0, 1'b0);
        add_request(hkvt_pkg::OP_REMOVE, key_pool[0][1], '0, 1'b0);
        add_request(hkvt_pkg::OP_INSERT, key_pool[0][WAYS], '1, 1'b0);  // reuses the freed way
        add_request(hkvt_pkg::OP_LOOKUP, key_pool[0][WAYS], '0, 1'b0);
        add_request(hkvt_pkg::OP_LOOKUP, key_pool[0][0], '0, 1'b0);

        // random: mostly pool keys so buckets fill, collide and drain
        for (int i = 0; i < N_RANDOM; i++) begin
            r = $urandom_range(99);
            if (r < 40)      op = hkvt_pkg::OP_INSERT;
            else if (r < 65) op = hkvt_pkg::OP_REMOVE;
            else if (r < 95) op = hkvt_pkg::OP_LOOKUP;
            else             op = OP_UNUSED;
            if ($urandom_range(99) < 85)
                k = key_pool[$urandom_range(BUCKETS - 1)][$urandom_range(POOL_N - 1)];
            else
                k = $urandom;
            r = $urandom_range(19);
            if (r == 0)      v = '0;
            else if (r == 1) v = '1;
            else             v = {$urandom, $urandom};
            // pause for a full drain at the start and near each phase change
            add_request(op, k, v, (i == 0 || i == 360 || i == 740));
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        do @(posedge aclk);
        while (pending_requests.size() != 0 || s_valid || in_flight != 0);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (expected_results.size() != 0)
            report_mismatch("results never delivered, count",
                            DATA_W'(expected_results.size()), '0);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* hashed_key_value_table.f */
design/hkvt_pkg.sv
design/hkvt_mix_unit.sv
design/hashed_key_value_table.sv
tb/tb_hashed_key_value_table.sv
